>>> rtl/core/rmsn_pkg.sv
package rmsn_pkg;

    localparam int DATA_W  = 16;
    localparam int MAX_DIM = 64;
    localparam int ADDR_W  = 6;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 38;
    localparam int EPS_W   = 32;
    localparam int X_W     = 39;
    localparam int REM_W   = 40;
    localparam int QUO_W   = 74;
    localparam int INV_W   = 37;
    localparam int ENTRY_W = 32;
    localparam int EPS_RESET = 168;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_MEAN,
        RS_RECIP,
        RS_ROOT
    } t_rs_state;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_CALC,
        ST_READ,
        ST_MULA,
        ST_MULB,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/core/rmsn_if.sv
interface rmsn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] value;
    logic signed [15:0] weight;
    logic               last;
    modport source (output valid, output value, output weight, output last, input ready);
    modport sink (input valid, input value, input weight, input last, output ready);
endinterface

interface rmsn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] result;
    logic        [5:0]  position;
    logic               end_of_row;
    modport source (output valid, output result, output position, output end_of_row,
                    input ready);
    modport sink (input valid, input result, input position, input end_of_row,
                  output ready);
endinterface

interface rmsn_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/rmsn_mem.sv
module rmsn_mem
    import rmsn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [MAX_DIM];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/rmsn_rsqrt.sv
module rmsn_rsqrt
    import rmsn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum,
    input  logic [CNT_W-1:0] i_count,
    input  logic [EPS_W-1:0] i_eps,
    output logic             o_done,
    output logic [INV_W-1:0] o_inv
);

    t_rs_state          r_state, n_state;
    logic [CNT_W-1:0]   r_step, n_step;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [INV_W-1:0]   r_root, n_root;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [X_W-1:0]     r_x, n_x;
    logic [EPS_W-1:0]   r_eps, n_eps;
    logic               r_done, n_done;

    logic [REM_W-1:0]   trial;
    logic [REM_W-1:0]   divisor;
    logic [X_W-1:0]     xsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_step  <= n_step;
        end
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_root <= n_root;
        r_n    <= n_n;
        r_x    <= n_x;
        r_eps  <= n_eps;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_root  = r_root;
        n_n     = r_n;
        n_x     = r_x;
        n_eps   = r_eps;
        n_done  = 1'b0;
        trial   = '0;
        divisor = '0;
        xsum    = '0;
        unique case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    n_state = RS_MEAN;
                    n_step  = CNT_W'(SUM_W - 1);
                    n_rem   = '0;
                    n_quo   = QUO_W'(i_sum);
                    n_n     = i_count;
                    n_eps   = i_eps;
                end
            end
            RS_MEAN: begin
                trial   = {r_rem[REM_W-2:0], r_quo[SUM_W-1]};
                divisor = REM_W'(r_n);
                if (trial >= divisor) begin
                    n_rem = trial - divisor;
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    xsum    = X_W'(n_quo[SUM_W-1:0]) + X_W'(r_eps);
                    n_state = RS_RECIP;
                    n_step  = CNT_W'(72);
                    n_rem   = '0;
                    n_x     = (xsum == '0) ? X_W'(1) : xsum;
                end
            end
            RS_RECIP: begin
                trial   = {r_rem[REM_W-2:0], (r_step == CNT_W'(72))};
                divisor = REM_W'(r_x);
                if (trial >= divisor) begin
                    n_rem = trial - divisor;
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_quo   = {1'b0, r_quo[QUO_W-3:0], (trial >= divisor)};
                    n_state = RS_ROOT;
                    n_step  = CNT_W'(INV_W - 1);
                    n_rem   = '0;
                    n_root  = '0;
                end
            end
            RS_ROOT: begin
                trial   = {r_rem[REM_W-3:0], r_quo[QUO_W-1:QUO_W-2]};
                divisor = REM_W'({r_root, 2'b01});
                if (trial >= divisor) begin
                    n_rem  = trial - divisor;
                    n_root = {r_root[INV_W-2:0], 1'b1};
                end else begin
                    n_rem  = trial;
                    n_root = {r_root[INV_W-2:0], 1'b0};
                end
                n_quo  = {r_quo[QUO_W-3:0], 2'b00};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = RS_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = RS_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_inv  = r_root;

endmodule

>>> rtl/core/rmsn_scale.sv
module rmsn_scale
    import rmsn_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic        [INV_W-1:0]  i_inv,
    output logic        [DATA_W-1:0] o_result
);

    logic signed [2*DATA_W-1:0] prod;
    logic        [2*DATA_W-1:0] mag;
    logic                       r_neg_a, r_neg_b;
    logic        [30:0]         r_mag;
    logic        [62:0]         r_plo;
    logic        [35:0]         r_phi;
    logic        [68:0]         total;
    logic        [32:0]         q;
    logic        [32:0]         pmax;

    assign prod = i_value * i_weight;
    assign mag  = prod[2*DATA_W-1] ? (~prod + 1'b1) : prod;

    always_ff @(posedge i_clk) begin
        r_neg_a <= prod[2*DATA_W-1];
        r_mag   <= mag[30:0];
        r_neg_b <= r_neg_a;
        r_plo   <= 63'(r_mag) * 63'(i_inv[31:0]);
        r_phi   <= 36'(r_mag) * 36'(i_inv[INV_W-1:32]);
    end

    assign pmax  = 33'((1 << (DATA_W - 1)) - 1);
    assign total = 69'(r_plo) + {1'b0, r_phi, 32'b0} + (69'(1) << 35);
    assign q     = total[68:36];

    always_comb begin
        if (r_neg_b) begin
            o_result = (q > pmax) ? DATA_W'(pmax + 1'b1) : DATA_W'(~q + 1'b1);
            if (q > pmax) begin
                o_result = DATA_W'(~(pmax + 1'b1) + 1'b1);
            end
        end else begin
            o_result = (q > pmax) ? DATA_W'(pmax) : DATA_W'(q);
        end
    end

endmodule

>>> rtl/core/rms_normalizer.sv
// Rows load at one element per cycle while in the load state; the item marked last starts
// the normaliser: a 38-step mean division, a 73-step reciprocal division and a 37-step
// square root come before the first result.
// Each result then passes through a store read, two multiply stages and rounding.
// Synchronous active-low reset clears the control state and sets epsilon to 168.
module rms_normalizer
    import rmsn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmsn_in_if.sink    i_item,
    rmsn_cfg_if.sink   i_cfg,
    rmsn_out_if.source o_res
);

    t_state             r_state, n_state;
    logic [EPS_W-1:0]   r_eps;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_k, n_k;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_result, n_result;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic               r_eor, n_eor;

    logic               accept;
    logic               mem_we;
    logic [ENTRY_W-1:0] rdata;
    logic               rs_start;
    logic               rs_done;
    logic [INV_W-1:0]   inv;
    logic [DATA_W-1:0]  scaled;
    logic signed [2*DATA_W-1:0] square;
    logic               is_last_k;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == ST_LOAD);
    assign accept       = i_item.valid && i_item.ready;
    assign mem_we       = accept && (r_count < CNT_W'(MAX_DIM));
    assign square       = i_item.value * i_item.value;
    assign rs_start     = (r_state == ST_START);
    assign is_last_k    = (CNT_W'(r_k) + 1'b1 == r_count);

    rmsn_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_item.weight, i_item.value}),
        .i_raddr (r_k),
        .o_rdata (rdata)
    );

    rmsn_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rs_start),
        .i_sum   (r_sum),
        .i_count (r_count),
        .i_eps   (r_eps),
        .o_done  (rs_done),
        .o_inv   (inv)
    );

    rmsn_scale u_scale (
        .i_clk    (i_clk),
        .i_value  (rdata[DATA_W-1:0]),
        .i_weight (rdata[ENTRY_W-1:ENTRY_W-DATA_W]),
        .i_inv    (inv),
        .o_result (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_eps       <= EPS_W'(EPS_RESET);
            r_sum       <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_eps <= i_cfg.data;
            end
        end
        r_result <= n_result;
        r_pos    <= n_pos;
        r_eor    <= n_eor;
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_count     = r_count;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_res.ready;
        n_result    = r_result;
        n_pos       = r_pos;
        n_eor       = r_eor;
        unique case (r_state)
            ST_LOAD: begin
                if (mem_we) begin
                    n_sum   = r_sum + SUM_W'(unsigned'(square));
                    n_count = r_count + 1'b1;
                end
                if (accept && i_item.last) begin
                    n_state = ST_START;
                end
            end
            ST_START: n_state = ST_CALC;
            ST_CALC: begin
                n_k = '0;
                if (rs_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_MULA;
            ST_MULA: n_state = ST_MULB;
            ST_MULB: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_result    = scaled;
                    n_pos       = r_k;
                    n_eor       = is_last_k;
                    if (is_last_k) begin
                        n_state = ST_LOAD;
                        n_sum   = '0;
                        n_count = '0;
                        n_k     = '0;
                    end else begin
                        n_state = ST_READ;
                        n_k     = r_k + 1'b1;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.result     = r_result;
    assign o_res.position   = r_pos;
    assign o_res.end_of_row = r_eor;

endmodule
